// File: sv/teg_pkg.sv
`timescale 1ns / 1ps

package teg_pkg;

    localparam int DEF_MAX_SIDE    = 128;
    localparam int DEF_HEIGHT_BITS = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic [7:0]  RST_GRID_SIDE   = 8'd64;
    localparam logic [8:0]  RST_PASS_COUNT  = 9'd1;
    localparam logic [22:0] RST_ORTH_LIMIT  = 23'd256;
    localparam logic [22:0] RST_DIAG_LIMIT  = 23'd362;
    localparam logic [22:0] RST_MATTER      = 23'd16;

    localparam logic [8:0]  PASS_LIMIT = 9'd500;
    localparam logic [3:0]  NB_LAST    = 4'd8;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_SIDE  = 3'd0,
        REG_PASS_COUNT = 3'd1,
        REG_ORTH_LIMIT = 3'd2,
        REG_DIAG_LIMIT = 3'd3,
        REG_MATTER     = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_READ_WAIT,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef enum logic [1:0] {
        OFS_MINUS,
        OFS_ZERO,
        OFS_PLUS
    } ofs_t;

    typedef struct packed {
        ofs_t dx;
        ofs_t dz;
        logic diag;
    } nb_ofs_t;

    function automatic nb_ofs_t nb_offset(input logic [3:0] nb);
        nb_ofs_t o;
        case (nb)
            4'd0:    o = '{OFS_ZERO,  OFS_ZERO,  1'b0};
            4'd1:    o = '{OFS_MINUS, OFS_MINUS, 1'b1};
            4'd2:    o = '{OFS_ZERO,  OFS_MINUS, 1'b0};
            4'd3:    o = '{OFS_PLUS,  OFS_MINUS, 1'b1};
            4'd4:    o = '{OFS_MINUS, OFS_ZERO,  1'b0};
            4'd5:    o = '{OFS_PLUS,  OFS_ZERO,  1'b0};
            4'd6:    o = '{OFS_MINUS, OFS_PLUS,  1'b1};
            4'd7:    o = '{OFS_ZERO,  OFS_PLUS,  1'b0};
            4'd8:    o = '{OFS_PLUS,  OFS_PLUS,  1'b1};
            default: o = '{OFS_ZERO,  OFS_ZERO,  1'b0};
        endcase
        return o;
    endfunction

endpackage

// File: sv/teg_ram.sv
`timescale 1ns / 1ps

module teg_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/thermal_erosion_grid_engine.sv
`timescale 1ns / 1ps

// Thermal erosion engine over a square, wrapped height grid held in two RAM banks.
// A request is taken when start is high and busy is low; its single result appears
// on height_out and status for one cycle with done high and cannot be held off.
// A write answers from the access state, an in-range read from read-wait after it.
// A run performs min(pass_count, 500) passes; each pass fetches the nine cells of
// every grid cell through the one read port of the current bank, and a run answers
// once its last pass has drained. Configuration writes take effect at once and
// belong to idle periods.

module thermal_erosion_grid_engine
    import teg_pkg::*;
#(
    parameter int MAX_SIDE    = DEF_MAX_SIDE,
    parameter int HEIGHT_BITS = DEF_HEIGHT_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              func,
    input  logic [13:0]             cell_index,
    input  logic signed [23:0]      height_in,
    output logic                    done,
    output logic signed [23:0]      height_out,
    output logic                    status,
    input  logic                    cfg_write,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH   = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int COORD_W = $clog2(MAX_SIDE);
    localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
    localparam int SQ_W    = 2 * SIDE_W;
    localparam int DW      = (HEIGHT_BITS > 23 ? HEIGHT_BITS : 23) + 2;
    localparam int WIDE_W  = (HEIGHT_BITS > 29 ? HEIGHT_BITS : 29) + 1;

    localparam logic signed [WIDE_W-1:0] H_MAX =
        signed'(WIDE_W'((33'd1 << (HEIGHT_BITS - 1)) - 33'd1));
    localparam logic signed [WIDE_W-1:0] H_MIN = -H_MAX - WIDE_W'(1);

    function automatic logic signed [HEIGHT_BITS-1:0] sat_h(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [HEIGHT_BITS-1:0] r;
        if (v > H_MAX)
        begin
            r = HEIGHT_BITS'(H_MAX);
        end
        else if (v < H_MIN)
        begin
            r = HEIGHT_BITS'(H_MIN);
        end
        else
        begin
            r = HEIGHT_BITS'(v);
        end
        return r;
    endfunction

    state_t state_reg, state_next;

    logic [7:0]  grid_side_reg;
    logic [8:0]  pass_count_reg;
    logic [22:0] orth_limit_reg;
    logic [22:0] diag_limit_reg;
    logic [22:0] matter_reg;

    logic [1:0]                    req_func_reg,  req_func_next;
    logic [ADDR_W-1:0]             req_addr_reg,  req_addr_next;
    logic                          req_oob_reg,   req_oob_next;
    logic signed [HEIGHT_BITS-1:0] req_h_reg,     req_h_next;
    logic [8:0]                    pass_total_reg, pass_total_next;
    logic [8:0]                    pass_reg,      pass_next;
    logic                          bank_reg,      bank_next;

    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] z_reg, z_next;
    logic [3:0]         nb_reg, nb_next;
    logic [ADDR_W-1:0]  cell_addr_reg, cell_addr_next;

    logic                          rd_valid_reg, rd_valid_next;
    logic [3:0]                    rd_nb_reg,    rd_nb_next;
    logic                          rd_diag_reg,  rd_diag_next;
    logic signed [HEIGHT_BITS-1:0] h_reg,        h_next;
    logic signed [4:0]             net_reg,      net_next;

    logic                          wb_valid_reg, wb_valid_next;
    logic [ADDR_W-1:0]             wb_addr_reg,  wb_addr_next;
    logic signed [HEIGHT_BITS-1:0] wb_h_reg,     wb_h_next;
    logic signed [4:0]             wb_net_reg,   wb_net_next;

    logic               done_reg,   done_next;
    logic               status_reg, status_next;
    logic signed [23:0] hout_reg,   hout_next;

    logic [SIDE_W-1:0]  side;
    logic [COORD_W-1:0] side_m1;
    logic [SQ_W-1:0]    side_sq;
    logic               idx_oob;
    logic [8:0]         pass_limited;
    logic               accept;
    logic               issue;
    logic               issue_last;
    logic               pass_end;
    logic               last_pass;
    logic               acc_we;

    nb_ofs_t            ofs;
    logic [COORD_W-1:0] xm, xp, zm, zp, qx, qz;
    logic [ADDR_W-1:0]  nb_addr;

    logic [ADDR_W-1:0]             raddr;
    logic [ADDR_W-1:0]             waddr;
    logic [HEIGHT_BITS-1:0]        wdata;
    logic                          we_a, we_b;
    logic [HEIGHT_BITS-1:0]        rdata_a, rdata_b;
    logic signed [HEIGHT_BITS-1:0] rdata;

    logic signed [DW-1:0]     d_up;
    logic signed [DW-1:0]     lim_w;
    logic signed [4:0]        net_acc;
    logic signed [WIDE_W-1:0] wb_sum;
    logic signed [HEIGHT_BITS-1:0] new_h;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg  <= RST_GRID_SIDE;
            pass_count_reg <= RST_PASS_COUNT;
            orth_limit_reg <= RST_ORTH_LIMIT;
            diag_limit_reg <= RST_DIAG_LIMIT;
            matter_reg     <= RST_MATTER;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_SIDE:  grid_side_reg  <= cfg_data[7:0];
                REG_PASS_COUNT: pass_count_reg <= cfg_data[8:0];
                REG_ORTH_LIMIT: orth_limit_reg <= cfg_data;
                REG_DIAG_LIMIT: diag_limit_reg <= cfg_data;
                REG_MATTER:     matter_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (grid_side_reg < 8'd3)
        begin
            side = SIDE_W'(3);
        end
        else if (32'(grid_side_reg) > 32'(MAX_SIDE))
        begin
            side = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side = SIDE_W'(grid_side_reg);
        end
    end

    assign side_m1      = COORD_W'(side - SIDE_W'(1));
    assign side_sq      = SQ_W'(side) * SQ_W'(side);
    assign idx_oob      = 32'(cell_index) >= 32'(side_sq);
    assign pass_limited = (pass_count_reg > PASS_LIMIT) ? PASS_LIMIT : pass_count_reg;

    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;
    assign issue      = (state_reg == ST_RUN);
    assign issue_last = issue && (nb_reg == NB_LAST) && (x_reg == side_m1) && (z_reg == side_m1);
    assign pass_end   = (state_reg == ST_DRAIN) && !rd_valid_reg && !wb_valid_reg;
    assign last_pass  = (pass_reg == pass_total_reg - 9'd1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (func == FUNC_RUN && pass_limited != 9'd0)
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        state_next = ST_ACCESS;
                    end
                end
            end
            ST_ACCESS:
            begin
                if (req_func_reg == FUNC_READ && !req_oob_reg)
                begin
                    state_next = ST_READ_WAIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ_WAIT:
            begin
                state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pass_end)
                begin
                    state_next = last_pass ? ST_IDLE : ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and memory control
    always_comb
    begin
        acc_we      = 1'b0;
        done_next   = 1'b0;
        status_next = 1'b0;
        hout_next   = '0;
        case (state_reg)
            ST_ACCESS:
            begin
                acc_we = (req_func_reg == FUNC_WRITE) && !req_oob_reg;
                if (!(req_func_reg == FUNC_READ && !req_oob_reg))
                begin
                    done_next   = 1'b1;
                    status_next = req_oob_reg;
                end
            end
            ST_READ_WAIT:
            begin
                done_next = 1'b1;
                hout_next = 24'(WIDE_W'(rdata));
            end
            ST_DRAIN:
            begin
                done_next = pass_end && last_pass;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Neighbor address generation
    assign ofs = nb_offset(nb_reg);
    assign xm  = (x_reg == '0) ? side_m1 : x_reg - COORD_W'(1);
    assign xp  = (x_reg == side_m1) ? '0 : x_reg + COORD_W'(1);
    assign zm  = (z_reg == '0) ? side_m1 : z_reg - COORD_W'(1);
    assign zp  = (z_reg == side_m1) ? '0 : z_reg + COORD_W'(1);

    always_comb
    begin
        case (ofs.dx)
            OFS_MINUS: qx = xm;
            OFS_PLUS:  qx = xp;
            default:   qx = x_reg;
        endcase
        case (ofs.dz)
            OFS_MINUS: qz = zm;
            OFS_PLUS:  qz = zp;
            default:   qz = z_reg;
        endcase
    end

    assign nb_addr = ADDR_W'(qz) * ADDR_W'(side) + ADDR_W'(qx);

    // Memory banks
    assign raddr = issue ? nb_addr : req_addr_reg;
    assign waddr = wb_valid_reg ? wb_addr_reg : req_addr_reg;
    assign wdata = wb_valid_reg ? new_h : req_h_reg;
    assign we_a  = (acc_we && !bank_reg) || (wb_valid_reg && bank_reg);
    assign we_b  = (acc_we && bank_reg) || (wb_valid_reg && !bank_reg);
    assign rdata = bank_reg ? signed'(rdata_b) : signed'(rdata_a);

    teg_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_bank_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    teg_ram #(
        .WIDTH (HEIGHT_BITS),
        .DEPTH (DEPTH)
    ) u_bank_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    // Talus compare and write-back arithmetic
    assign d_up  = DW'(rdata) - DW'(h_reg);
    assign lim_w = signed'(DW'(rd_diag_reg ? diag_limit_reg : orth_limit_reg));

    always_comb
    begin
        if (d_up > lim_w)
        begin
            net_acc = net_reg + 5'sd1;
        end
        else if (-d_up > lim_w)
        begin
            net_acc = net_reg - 5'sd1;
        end
        else
        begin
            net_acc = net_reg;
        end
    end

    assign wb_sum = WIDE_W'(wb_h_reg)
                  + signed'(WIDE_W'(matter_reg)) * WIDE_W'(wb_net_reg);
    assign new_h  = sat_h(wb_sum);

    // Datapath next values
    always_comb
    begin
        req_func_next   = req_func_reg;
        req_addr_next   = req_addr_reg;
        req_oob_next    = req_oob_reg;
        req_h_next      = req_h_reg;
        pass_total_next = pass_total_reg;
        pass_next       = pass_reg;
        bank_next       = bank_reg;
        x_next          = x_reg;
        z_next          = z_reg;
        nb_next         = nb_reg;
        cell_addr_next  = cell_addr_reg;
        rd_valid_next   = issue;
        rd_nb_next      = nb_reg;
        rd_diag_next    = ofs.diag;
        h_next          = h_reg;
        net_next        = net_reg;
        wb_valid_next   = 1'b0;
        wb_addr_next    = wb_addr_reg;
        wb_h_next       = wb_h_reg;
        wb_net_next     = wb_net_reg;

        if (accept)
        begin
            req_func_next   = func;
            req_addr_next   = ADDR_W'(32'(cell_index));
            req_oob_next    = idx_oob && (func == FUNC_WRITE || func == FUNC_READ);
            req_h_next      = sat_h(WIDE_W'(height_in));
            pass_total_next = pass_limited;
            pass_next       = '0;
            x_next          = '0;
            z_next          = '0;
            nb_next         = '0;
        end

        if (issue)
        begin
            if (nb_reg == '0)
            begin
                cell_addr_next = nb_addr;
            end
            if (nb_reg == NB_LAST)
            begin
                nb_next = '0;
                if (x_reg == side_m1)
                begin
                    x_next = '0;
                    z_next = (z_reg == side_m1) ? '0 : z_reg + COORD_W'(1);
                end
                else
                begin
                    x_next = x_reg + COORD_W'(1);
                end
            end
            else
            begin
                nb_next = nb_reg + 4'd1;
            end
        end

        if (rd_valid_reg)
        begin
            if (rd_nb_reg == '0)
            begin
                h_next   = rdata;
                net_next = '0;
            end
            else
            begin
                net_next = net_acc;
            end
            if (rd_nb_reg == NB_LAST)
            begin
                wb_valid_next = 1'b1;
                wb_addr_next  = cell_addr_reg;
                wb_h_next     = h_reg;
                wb_net_next   = net_acc;
            end
        end

        if (pass_end)
        begin
            bank_next = !bank_reg;
            pass_next = pass_reg + 9'd1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            pass_reg     <= '0;
            x_reg        <= '0;
            z_reg        <= '0;
            nb_reg       <= '0;
            rd_valid_reg <= 1'b0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            pass_reg     <= pass_next;
            x_reg        <= x_next;
            z_reg        <= z_next;
            nb_reg       <= nb_next;
            rd_valid_reg <= rd_valid_next;
            wb_valid_reg <= wb_valid_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        req_func_reg   <= req_func_next;
        req_addr_reg   <= req_addr_next;
        req_oob_reg    <= req_oob_next;
        req_h_reg      <= req_h_next;
        pass_total_reg <= pass_total_next;
        cell_addr_reg  <= cell_addr_next;
        rd_nb_reg      <= rd_nb_next;
        rd_diag_reg    <= rd_diag_next;
        h_reg          <= h_next;
        net_reg        <= net_next;
        wb_addr_reg    <= wb_addr_next;
        wb_h_reg       <= wb_h_next;
        wb_net_reg     <= wb_net_next;
        status_reg     <= status_next;
        hout_reg       <= hout_next;
    end

    assign done       = done_reg;
    assign status     = status_reg;
    assign height_out = hout_reg;

endmodule

// File: sv/teg_checker.sv
`timescale 1ns / 1ps

module teg_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic               status,
    input logic signed [23:0] height_out
);

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a request");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (height_out == 24'sd0))
        else $error("error result carries a nonzero height");

endmodule

bind thermal_erosion_grid_engine teg_checker u_teg_checker (.*);
